@@ rtl/core/pkb_pkg.sv @@
package pkb_pkg;

    // packet limits
    localparam int MAX_PACKET = 127;
    localparam int BREAK_RUN  = 4;

    // literal buffer: one bank holds the open literal packet
    localparam int LIT_DEPTH = 128;
    localparam int IDX_W     = $clog2(LIT_DEPTH);
    localparam int CNT_W     = $clog2(MAX_PACKET + 1);
    localparam int FILL_W    = $clog2(BREAK_RUN);

    // command queue between front and back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    localparam int WORD_BYTES = 8;
    localparam int LANE_W     = $clog2(WORD_BYTES);

    localparam logic [8:0] REPEAT_HDR_BASE = 9'h101;

    typedef enum logic {
        CMD_REPEAT,
        CMD_LITERAL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [CNT_W-1:0] cnt;
        logic [7:0]       value;
        logic             bank;
        logic             last;
        logic             row_end;
        logic             strip_end;
    } cmd_t;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
    } lit_wr_t;

endpackage

@@ rtl/core/pkb_cmd_fifo.sv @@
module pkb_cmd_fifo
    import pkb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty,
    output logic room2
);

    cmd_t                 entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W:0]   level_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + CMD_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + CMD_PTR_W'(1);
            end
            if (push && !pop) begin
                level_reg <= level_reg + (CMD_PTR_W+1)'(1);
            end else if (pop && !push) begin
                level_reg <= level_reg - (CMD_PTR_W+1)'(1);
            end
        end
    end

    assign head_cmd = entry_reg[rd_ptr_reg];
    assign empty    = (level_reg == '0);
    assign room2    = (level_reg <= (CMD_PTR_W+1)'(CMD_DEPTH - 2));

endmodule

@@ rtl/core/pkb_front.sv @@
module pkb_front
    import pkb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic [15:0] row_bytes,
    input  logic [15:0] rows_per_strip,
    input  logic        q_room2,
    output logic        q_push,
    output cmd_t        q_cmd,
    output lit_wr_t     lit_wr,
    input  logic [1:0]  bank_release
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_FIRST,
        MODE_REPEAT,
        MODE_LITERAL
    } mode_t;

    mode_t             mode_reg, mode_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        run_byte_reg, run_byte_next;
    logic [15:0]       col_reg, col_next;
    logic [15:0]       row_reg, row_next;
    logic              bank_reg, bank_next;
    logic [1:0]        busy_reg, busy_next;
    logic              pend_reg, pend_next;
    cmd_t              pend_cmd_reg, pend_cmd_next;

    logic        accept, match, full_lit, check;
    logic        bank_mid;
    logic        c1_v, c2_v;
    cmd_t        c1, c2;
    logic [15:0] col_inc, row_inc;
    logic        row_done, strip_done;

    function automatic cmd_t mk_cmd(cmd_kind_t k, logic [CNT_W-1:0] n, logic [7:0] v,
                                    logic bk);
        cmd_t c;
        c           = '0;
        c.kind      = k;
        c.cnt       = n;
        c.value     = v;
        c.bank      = bk;
        return c;
    endfunction

    always_comb begin
        full_lit = (mode_reg == MODE_LITERAL) && (count_reg >= CNT_W'(MAX_PACKET));
        // start_first writes the active bank; a full literal restarts in the other one
        s_ready  = !pend_reg && q_room2 && !busy_reg[bank_reg] &&
                   !(full_lit && busy_reg[~bank_reg]);
        accept   = s_valid && s_ready;
        match    = (s_in_byte == run_byte_reg);

        mode_next     = mode_reg;
        count_next    = count_reg;
        fill_next     = fill_reg;
        run_byte_next = run_byte_reg;
        bank_mid      = bank_reg;
        check         = 1'b0;
        c1_v          = 1'b0;
        c1            = '0;
        c2_v          = 1'b0;
        c2            = '0;
        lit_wr        = '0;

        unique case (mode_reg)
            MODE_IDLE: begin
                lit_wr        = '{en: 1'b1, bank: bank_reg, idx: '0, data: s_in_byte};
                run_byte_next = s_in_byte;
                count_next    = CNT_W'(1);
                fill_next     = '0;
                mode_next     = MODE_FIRST;
            end
            MODE_FIRST: begin
                if (match) begin
                    count_next = CNT_W'(2);
                    fill_next  = '0;
                    mode_next  = MODE_REPEAT;
                    if (MAX_PACKET <= 2) begin
                        c1_v       = 1'b1;
                        c1         = mk_cmd(CMD_REPEAT, CNT_W'(2), s_in_byte, bank_reg);
                        mode_next  = MODE_IDLE;
                        count_next = '0;
                    end
                end else begin
                    lit_wr        = '{en: 1'b1, bank: bank_reg, idx: IDX_W'(1),
                                      data: s_in_byte};
                    count_next    = CNT_W'(2);
                    run_byte_next = s_in_byte;
                    fill_next     = FILL_W'(1);
                    mode_next     = MODE_LITERAL;
                    check         = 1'b1;
                end
            end
            MODE_REPEAT: begin
                if (match) begin
                    count_next = count_reg + CNT_W'(1);
                    if (count_next >= CNT_W'(MAX_PACKET)) begin
                        c1_v       = 1'b1;
                        c1         = mk_cmd(CMD_REPEAT, count_next, run_byte_reg, bank_reg);
                        mode_next  = MODE_IDLE;
                        count_next = '0;
                    end
                end else begin
                    c1_v          = 1'b1;
                    c1            = mk_cmd(CMD_REPEAT, count_reg, run_byte_reg, bank_reg);
                    lit_wr        = '{en: 1'b1, bank: bank_reg, idx: '0, data: s_in_byte};
                    run_byte_next = s_in_byte;
                    count_next    = CNT_W'(1);
                    fill_next     = '0;
                    mode_next     = MODE_FIRST;
                end
            end
            MODE_LITERAL: begin
                if (match && fill_reg == FILL_W'(BREAK_RUN - 1)) begin
                    // run of BREAK_RUN: literal keeps the bytes before it
                    c1_v          = 1'b1;
                    c1            = mk_cmd(CMD_LITERAL, count_reg - CNT_W'(BREAK_RUN - 1),
                                           run_byte_reg, bank_reg);
                    bank_mid      = ~bank_reg;
                    run_byte_next = s_in_byte;
                    count_next    = CNT_W'(BREAK_RUN);
                    fill_next     = '0;
                    mode_next     = MODE_REPEAT;
                end else if (full_lit) begin
                    c1_v          = 1'b1;
                    c1            = mk_cmd(CMD_LITERAL, count_reg, run_byte_reg, bank_reg);
                    bank_mid      = ~bank_reg;
                    lit_wr        = '{en: 1'b1, bank: ~bank_reg, idx: '0, data: s_in_byte};
                    run_byte_next = s_in_byte;
                    count_next    = CNT_W'(1);
                    fill_next     = '0;
                    mode_next     = MODE_FIRST;
                end else begin
                    lit_wr     = '{en: 1'b1, bank: bank_reg, idx: IDX_W'(count_reg),
                                   data: s_in_byte};
                    count_next = count_reg + CNT_W'(1);
                    if (match) begin
                        fill_next = fill_reg + FILL_W'(1);
                    end else begin
                        run_byte_next = s_in_byte;
                        fill_next     = FILL_W'(1);
                    end
                    check = 1'b1;
                end
            end
        endcase

        // full literal closes unless its tail may still grow into a run
        if (check && count_next >= CNT_W'(MAX_PACKET) &&
            fill_next != FILL_W'(BREAK_RUN - 1)) begin
            c1_v       = 1'b1;
            c1         = mk_cmd(CMD_LITERAL, count_next, run_byte_next, bank_reg);
            bank_mid   = ~bank_reg;
            mode_next  = MODE_IDLE;
            count_next = '0;
            fill_next  = '0;
        end

        // row end counts as a mismatch and closes the open packet
        col_inc    = col_reg + 16'd1;
        row_inc    = row_reg + 16'd1;
        row_done   = (col_inc == row_bytes);
        strip_done = row_done && (row_inc == rows_per_strip);
        bank_next  = bank_mid;
        col_next   = row_done ? 16'd0 : col_inc;
        row_next   = row_reg;
        if (row_done) begin
            row_next = strip_done ? 16'd0 : row_inc;
            unique case (mode_next)
                MODE_FIRST: begin
                    c2_v      = 1'b1;
                    c2        = mk_cmd(CMD_LITERAL, CNT_W'(1), run_byte_next, bank_mid);
                    bank_next = ~bank_mid;
                end
                MODE_LITERAL: begin
                    c2_v      = 1'b1;
                    c2        = mk_cmd(CMD_LITERAL, count_next, run_byte_next, bank_mid);
                    bank_next = ~bank_mid;
                end
                MODE_REPEAT: begin
                    c2_v = 1'b1;
                    c2   = mk_cmd(CMD_REPEAT, count_next, run_byte_next, bank_mid);
                end
                MODE_IDLE: begin
                    c2_v = 1'b0;
                end
            endcase
            mode_next  = MODE_IDLE;
            count_next = '0;
            fill_next  = '0;
        end

        // step flags ride on the last command of the step
        if (c2_v) begin
            c2.last      = 1'b1;
            c2.row_end   = row_done;
            c2.strip_end = strip_done;
        end else begin
            c1.last      = 1'b1;
            c1.row_end   = row_done;
            c1.strip_end = strip_done;
        end

        pend_next     = accept && c1_v && c2_v;
        pend_cmd_next = c2;
        q_push        = 1'b0;
        q_cmd         = c1;
        if (pend_reg) begin
            q_push = 1'b1;
            q_cmd  = pend_cmd_reg;
        end else if (accept) begin
            q_push = c1_v || c2_v;
            q_cmd  = c1_v ? c1 : c2;
        end

        busy_next = busy_reg & ~bank_release;
        if (accept && c1_v && c1.kind == CMD_LITERAL) begin
            busy_next[bank_reg] = 1'b1;
        end
        if (accept && c2_v && c2.kind == CMD_LITERAL) begin
            busy_next[bank_mid] = 1'b1;
        end

        if (!accept) begin
            lit_wr.en = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            count_reg    <= '0;
            fill_reg     <= '0;
            run_byte_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            bank_reg     <= 1'b0;
            busy_reg     <= '0;
            pend_reg     <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            pend_reg <= pend_next;
            if (accept) begin
                mode_reg     <= mode_next;
                count_reg    <= count_next;
                fill_reg     <= fill_next;
                run_byte_reg <= run_byte_next;
                col_reg      <= col_next;
                row_reg      <= row_next;
                bank_reg     <= bank_next;
            end
        end
        if (pend_next) begin
            pend_cmd_reg <= pend_cmd_next;
        end
    end

endmodule

@@ rtl/core/pkb_back.sv @@
module pkb_back
    import pkb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        head_cmd,
    input  logic        q_empty,
    output logic        q_pop,
    input  lit_wr_t     lit_wr,
    output logic [1:0]  bank_release,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_out_word,
    output logic [3:0]  m_byte_count,
    output logic        m_row_end,
    output logic        m_strip_end,
    output logic        m_last_of_item
);

    typedef enum logic {
        PH_HEAD,
        PH_BODY
    } phase_t;

    // two banks of literal bytes, bank select on top
    logic [7:0] lit_mem [2*LIT_DEPTH];

    phase_t            phase_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              p_valid_reg;
    logic              p_from_mem_reg;
    logic [7:0]        p_byte_reg;
    logic              p_last_reg, p_row_reg, p_strip_reg;
    logic [7:0]        mem_q_reg;
    logic [63:0]       acc_reg;
    logic [LANE_W-1:0] acc_cnt_reg;
    logic              m_valid_reg;
    logic [63:0]       m_word_reg;
    logic [3:0]        m_count_reg;
    logic              m_row_reg, m_strip_reg, m_last_reg;

    logic        out_free, take, advance, issue, flush;
    logic        slot_mem, cmd_end;
    logic [7:0]  slot_byte, hdr_byte, p_data;
    logic [63:0] word_with;

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        take     = p_valid_reg && out_free;
        advance  = !p_valid_reg || take;
        issue    = advance && !q_empty;

        if (head_cmd.kind == CMD_REPEAT) begin
            hdr_byte = 8'(REPEAT_HDR_BASE - 9'(head_cmd.cnt));
        end else begin
            hdr_byte = 8'(head_cmd.cnt) - 8'd1;
        end

        slot_mem  = 1'b0;
        slot_byte = hdr_byte;
        cmd_end   = 1'b0;
        unique case (phase_reg)
            PH_HEAD: begin
                slot_byte = hdr_byte;
            end
            PH_BODY: begin
                if (head_cmd.kind == CMD_REPEAT) begin
                    slot_byte = head_cmd.value;
                    cmd_end   = 1'b1;
                end else begin
                    slot_mem = 1'b1;
                    cmd_end  = ((CNT_W'(idx_reg) + CNT_W'(1)) == head_cmd.cnt);
                end
            end
        endcase

        q_pop        = issue && cmd_end;
        bank_release = '0;
        if (issue && slot_mem && cmd_end) begin
            bank_release[head_cmd.bank] = 1'b1;
        end

        p_data = p_from_mem_reg ? mem_q_reg : p_byte_reg;
        flush  = p_last_reg || (acc_cnt_reg == LANE_W'(WORD_BYTES - 1));
        for (int i = 0; i < WORD_BYTES; i++) begin
            word_with[8*i +: 8] = (acc_cnt_reg == LANE_W'(i)) ? p_data : acc_reg[8*i +: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (lit_wr.en) begin
            lit_mem[{lit_wr.bank, lit_wr.idx}] <= lit_wr.data;
        end
        if (issue && slot_mem) begin
            mem_q_reg <= lit_mem[{head_cmd.bank, idx_reg}];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEAD;
            idx_reg     <= '0;
            p_valid_reg <= 1'b0;
            acc_reg     <= '0;
            acc_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (issue) begin
                unique case (phase_reg)
                    PH_HEAD: begin
                        phase_reg <= PH_BODY;
                        idx_reg   <= '0;
                    end
                    PH_BODY: begin
                        if (cmd_end) begin
                            phase_reg <= PH_HEAD;
                        end else begin
                            idx_reg <= idx_reg + IDX_W'(1);
                        end
                    end
                endcase
            end
            if (advance) begin
                p_valid_reg    <= issue;
                p_from_mem_reg <= slot_mem;
                p_byte_reg     <= slot_byte;
                p_last_reg     <= cmd_end && head_cmd.last;
                p_row_reg      <= cmd_end && head_cmd.row_end;
                p_strip_reg    <= cmd_end && head_cmd.strip_end;
            end
            if (take) begin
                if (flush) begin
                    acc_reg     <= '0;
                    acc_cnt_reg <= '0;
                end else begin
                    acc_reg     <= word_with;
                    acc_cnt_reg <= acc_cnt_reg + LANE_W'(1);
                end
            end
            if (take && flush) begin
                m_valid_reg <= 1'b1;
                m_word_reg  <= word_with;
                m_count_reg <= 4'(acc_cnt_reg) + 4'd1;
                m_row_reg   <= p_row_reg;
                m_strip_reg <= p_strip_reg;
                m_last_reg  <= p_last_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_word     = m_word_reg;
    assign m_byte_count   = m_count_reg;
    assign m_row_end      = m_row_reg;
    assign m_strip_end    = m_strip_reg;
    assign m_last_of_item = m_last_reg;

endmodule

@@ rtl/core/packbits_row_encoder_top.sv @@
// PackBits row encoder. Raw bytes enter one per transaction on the s_ channel and
// leave as a PackBits stream packed into words of up to eight bytes (first byte in
// bits 7:0, unused upper bytes zero) on the m_ channel; every row is coded on its
// own. A front end runs the packet state machine and writes literal bytes into one
// of two 128-byte banks; finished packets go as commands through a four-entry queue
// to a back end that emits one encoded byte per clock unless the output stalls,
// reading literal bytes from the bank read port, and packs the words. When an
// input byte closes two packets at once, the second command waits in a pending
// register and no new byte is taken until it is queued. Encoded output includes
// headers: n + 1 bytes for a literal packet of n bytes, two for a repeat packet.
// The front also stalls while the queue holds more than two commands or while
// the bank it must write next is still being read out. Config registers (APB,
// byte address 0: row_bytes, 4: rows_per_strip, both reset to 1) must be written
// only while the block is idle; the block itself does not enforce this.
module packbits_row_encoder_top
    import pkb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // APB config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // raw byte input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    // encoded word output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_out_word,
    output logic [3:0]  m_byte_count,
    output logic        m_row_end,
    output logic        m_strip_end,
    output logic        m_last_of_item
);

    // register index is paddr[2]
    localparam logic REG_ROW_BYTES      = 1'b0;
    localparam logic REG_ROWS_PER_STRIP = 1'b1;

    logic [15:0] row_bytes_reg;
    logic [15:0] rows_per_strip_reg;
    logic        cfg_wr;

    // front <-> queue <-> back
    logic    q_push, q_pop, q_empty, q_room2;
    cmd_t    q_cmd, head_cmd;
    lit_wr_t lit_wr;
    logic [1:0] bank_release;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_bytes_reg      <= 16'd1;
            rows_per_strip_reg <= 16'd1;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_ROW_BYTES:      row_bytes_reg      <= pwdata[15:0];
                REG_ROWS_PER_STRIP: rows_per_strip_reg <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ROW_BYTES:      prdata = {16'd0, row_bytes_reg};
            REG_ROWS_PER_STRIP: prdata = {16'd0, rows_per_strip_reg};
        endcase
    end

    // packet state machine, literal bank writes, command issue
    pkb_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .row_bytes      (row_bytes_reg),
        .rows_per_strip (rows_per_strip_reg),
        .q_room2        (q_room2),
        .q_push         (q_push),
        .q_cmd          (q_cmd),
        .lit_wr         (lit_wr),
        .bank_release   (bank_release)
    );

    // packet commands in flight
    pkb_cmd_fifo u_cmd_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .room2    (q_room2)
    );

    // byte sequencer, literal banks, word packer and output register
    pkb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_cmd       (head_cmd),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .lit_wr         (lit_wr),
        .bank_release   (bank_release),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_word     (m_out_word),
        .m_byte_count   (m_byte_count),
        .m_row_end      (m_row_end),
        .m_strip_end    (m_strip_end),
        .m_last_of_item (m_last_of_item)
    );

endmodule

@@ tb/packbits_row_encoder_top_tb.sv @@
module packbits_row_encoder_top_tb
    import pkb_pkg::*;
();

    // Register indexes; byte address is 4 * index.
    localparam int REG_ROW_BYTES      = 0;
    localparam int REG_ROWS_PER_STRIP = 1;

    // Quiet time after the last expected word before a register write. Covers
    // bytes still in flight in the front end that close no packet.
    localparam int DRAIN_CYCLES = 32;
    localparam int END_CYCLES   = 64;
    // Receiver hold-off during the backpressure phase.
    localparam int LONG_HOLD    = 400;

    // One output transaction, in port order.
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        row_end;
        logic        strip_end;
        logic        last;
    } enc_word_t;

    // Scoreboard: carries its own copy of the encoder state and the two config
    // registers, turns every accepted byte into the words it must produce, and
    // checks output words in order against them.
    class packbits_scoreboard;
        typedef enum logic [1:0] {
            ENC_IDLE,
            ENC_FIRST,
            ENC_REPEAT,
            ENC_LITERAL
        } enc_mode_t;

        enc_word_t   expected_words[$];
        int          errors;

        logic [7:0]  lit_bytes[128];
        logic [7:0]  run_byte;      // value of the trailing equal run
        logic [2:0]  run_len;       // length of that run inside a literal
        logic [7:0]  pkt_len;       // bytes in the open packet
        enc_mode_t   mode;
        logic [15:0] column;
        logic [15:0] row;
        logic [15:0] row_bytes;
        logic [15:0] rows_per_strip;
        logic [7:0]  coded[$];      // encoded bytes of the current transaction

        function new();
            foreach (lit_bytes[i]) lit_bytes[i] = '0;
            run_byte       = '0;
            run_len        = '0;
            pkt_len        = '0;
            mode           = ENC_IDLE;
            column         = '0;
            row            = '0;
            row_bytes      = 16'd1;
            rows_per_strip = 16'd1;
            errors         = 0;
        endfunction

        function void set_reg(int idx, logic [15:0] val);
            if (idx == REG_ROW_BYTES) begin
                row_bytes = val;
            end else if (idx == REG_ROWS_PER_STRIP) begin
                rows_per_strip = val;
            end
        endfunction

        function void put(int b);
            if (coded.size() < 144) coded.push_back(8'(b));
        endfunction

        function void close_repeat();
            put(int'(REPEAT_HDR_BASE) - int'(pkt_len));
            put(run_byte);
            mode    = ENC_IDLE;
            pkt_len = '0;
        endfunction

        function void close_literal(int n);
            int i;
            put(n - 1);
            for (i = 0; i < n && i < 128; i++) put(lit_bytes[i]);
            mode    = ENC_IDLE;
            pkt_len = '0;
            run_len = '0;
        endfunction

        function void begin_packet(logic [7:0] b);
            lit_bytes[0] = b;
            run_byte     = b;
            pkt_len      = 8'd1;
            run_len      = '0;
            mode         = ENC_FIRST;
        endfunction

        function void begin_repeat(logic [7:0] b, int n);
            run_byte = b;
            pkt_len  = 8'(n);
            run_len  = '0;
            mode     = ENC_REPEAT;
            if (n >= MAX_PACKET) close_repeat();
        endfunction

        // A full literal stays open only while its tail may still become a run.
        function void close_if_full();
            if (pkt_len >= MAX_PACKET && run_len != BREAK_RUN - 1) close_literal(pkt_len);
        endfunction

        function void encode_byte(logic [7:0] b);
            logic [7:0]  t;
            logic [15:0] next_col;
            logic [15:0] next_row;
            bit          row_done;
            bit          strip_done;
            int          nwords;
            int          cnt;
            int          k;
            int          i;
            enc_word_t   w;
            t          = run_byte;
            row_done   = 1'b0;
            strip_done = 1'b0;
            coded.delete();

            case (mode)
                ENC_IDLE: begin
                    begin_packet(b);
                end
                ENC_FIRST: begin
                    if (b == t) begin
                        begin_repeat(b, 2);
                    end else begin
                        lit_bytes[1] = b;
                        pkt_len      = 8'd2;
                        run_byte     = b;
                        run_len      = 3'd1;
                        mode         = ENC_LITERAL;
                        close_if_full();
                    end
                end
                ENC_REPEAT: begin
                    if (b == t) begin
                        pkt_len++;
                        if (pkt_len >= MAX_PACKET) close_repeat();
                    end else begin
                        close_repeat();
                        begin_packet(b);
                    end
                end
                default: begin
                    if (b == t && int'(run_len) + 1 == BREAK_RUN) begin
                        // run of four: literal ends before it, run moves to a repeat
                        close_literal(int'(pkt_len) - (BREAK_RUN - 1));
                        begin_repeat(b, BREAK_RUN);
                    end else if (pkt_len >= MAX_PACKET) begin
                        close_literal(pkt_len);
                        begin_packet(b);
                    end else begin
                        lit_bytes[pkt_len[6:0]] = b;
                        pkt_len++;
                        if (b == t) begin
                            run_len++;
                        end else begin
                            run_byte = b;
                            run_len  = 3'd1;
                        end
                        close_if_full();
                    end
                end
            endcase

            next_col = column + 16'd1;
            if (next_col == row_bytes) begin
                if (mode == ENC_FIRST) begin
                    close_literal(1);
                end else if (mode == ENC_LITERAL) begin
                    close_literal(pkt_len);
                end else if (mode == ENC_REPEAT) begin
                    close_repeat();
                end
                mode     = ENC_IDLE;
                column   = '0;
                row_done = 1'b1;
                next_row = row + 16'd1;
                if (next_row == rows_per_strip) begin
                    strip_done = 1'b1;
                    row        = '0;
                end else begin
                    row = next_row;
                end
            end else begin
                column = next_col;
            end

            nwords = (coded.size() + 7) / 8;
            for (k = 0; k < nwords; k++) begin
                cnt = coded.size() - 8 * k;
                if (cnt > 8) cnt = 8;
                w = '0;
                for (i = 0; i < cnt; i++) w.word[8*i +: 8] = coded[8*k + i];
                w.nbytes    = 4'(cnt);
                w.last      = (k == nwords - 1);
                w.row_end   = w.last && row_done;
                w.strip_end = w.last && strip_done;
                expected_words.push_back(w);
            end
        endfunction

        function void check_word(enc_word_t got);
            enc_word_t want;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h (%0d bytes)",
                         $time, got.word, got.nbytes);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got.word !== want.word) begin
                $display("%0t: out_word expected %h actual %h", $time, want.word, got.word);
                errors++;
            end
            if (got.nbytes !== want.nbytes) begin
                $display("%0t: byte_count expected %0d actual %0d",
                         $time, want.nbytes, got.nbytes);
                errors++;
            end
            if (got.row_end !== want.row_end) begin
                $display("%0t: row_end expected %b actual %b", $time, want.row_end, got.row_end);
                errors++;
            end
            if (got.strip_end !== want.strip_end) begin
                $display("%0t: strip_end expected %b actual %b",
                         $time, want.strip_end, got.strip_end);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last_of_item expected %b actual %b", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_out_word;
    logic [3:0]  m_byte_count;
    logic        m_row_end;
    logic        m_strip_end;
    logic        m_last_of_item;

    packbits_scoreboard sb;

    // Idle odds in percent for each side, changed between phases.
    int unsigned src_idle_pct = 6;
    int unsigned snk_idle_pct = 82;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit          long_hold_req = 1'b0;
    int          hold_left = 0;
    int          sent = 0;

    packbits_row_encoder_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_word     (m_out_word),
        .m_byte_count   (m_byte_count),
        .m_row_end      (m_row_end),
        .m_strip_end    (m_strip_end),
        .m_last_of_item (m_last_of_item)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Output monitor. Values are sampled as they stood before the edge, since
    // the block updates through nonblocking assignments.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_word({m_out_word, m_byte_count, m_row_end, m_strip_end, m_last_of_item});
        end
    end

    // Receiver. Random stalls at snk_idle_pct; on request it holds m_ready low
    // through one long hold-off so the queue and banks fill and s_ready drops.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // APB write with a setup phase and an access phase; the register takes the
    // value at the access edge, and the bus returns to idle before the next access.
    task automatic reg_write(input int idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= {16'h0000, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    // One input transaction. Valid stays high across back-to-back bytes and is
    // only lowered when the sender decides to idle.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.encode_byte(b);
        sent++;
    endtask

    // Stop sending and let every expected word come out, then let the front
    // end settle before config is touched.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One random segment. Mostly well-formed structures: runs (short, and long
    // enough to hit the 127 cap), small-alphabet stretches that make inner runs
    // of two and three and runs of four, and literals sized to fill up to the
    // cap with a run of three to five bytes at the end. The rest is plain noise.
    task automatic send_segment();
        logic [7:0]  v;
        logic [7:0]  x;
        logic [7:0]  y;
        int unsigned pick;
        int unsigned len;
        int          i;
        pick = $urandom_range(99);
        v    = 8'($urandom);
        x    = 8'($urandom);
        y    = x ^ 8'($urandom_range(255, 1));
        if (pick < 35) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(200, 120) : $urandom_range(10, 1);
            repeat (len) send_byte(v);
        end else if (pick < 65) begin
            len = $urandom_range(40, 2);
            repeat (len) send_byte(v + 8'($urandom_range(2)));
        end else if (pick < 77) begin
            // keep the alternation from touching the open packet's tail
            while (x == sb.run_byte || y == sb.run_byte) begin
                x = 8'($urandom);
                y = x ^ 8'($urandom_range(255, 1));
            end
            len = 124;
            if ((sb.mode == packbits_scoreboard::ENC_LITERAL ||
                 sb.mode == packbits_scoreboard::ENC_FIRST) && sb.pkt_len < 120) begin
                len = 124 - int'(sb.pkt_len);
            end
            for (i = 0; i < len; i++) send_byte(i[0] ? x : y);
            if (v == x || v == y) v = x + y + 8'd1;
            if (v == x || v == y) v = x ^ y ^ 8'h55;
            repeat ($urandom_range(5, 3)) send_byte(v);
        end else begin
            repeat ($urandom_range(8, 1)) send_byte(8'($urandom));
        end
    endtask

    // A random phase at one config setting. If the new row length is already
    // behind the current column, the open row is ended first so the run does
    // not wait for the column counter to wrap.
    task automatic run_phase(input logic [15:0] rb, input logic [15:0] rps, input int items);
        int first;
        if (rb != 0 && rb <= sb.column) begin
            reg_write(REG_ROW_BYTES, sb.column + 16'd1);
            send_byte(8'($urandom));
            drain();
        end
        reg_write(REG_ROW_BYTES, rb);
        reg_write(REG_ROWS_PER_STRIP, rps);
        first = sent;
        while (sent - first < items) send_segment();
        drain();
    endtask

    initial begin
        // Row of 20: a repeat of three, a literal carrying inner runs of two and
        // three that stops before a run of five, extremes 00/FF/80/7F, and a final
        // literal that the row end closes.
        logic [7:0] directed_row [20];
        sb = new();
        directed_row = '{
            8'h00, 8'h00, 8'h00,
            8'h12, 8'h34, 8'h34, 8'h56, 8'h56, 8'h56, 8'h78,
            8'hab, 8'hab, 8'hab, 8'hab, 8'hab,
            8'hff, 8'h80, 8'h7f, 8'h7f,
            8'h55
        };
        aresetn   <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        s_valid   <= 1'b0;
        s_in_byte <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset config: every byte is a row and every row a strip.
        send_byte(8'h00);
        send_byte(8'hff);
        drain();
        reg_write(REG_ROW_BYTES, 16'd20);
        reg_write(REG_ROWS_PER_STRIP, 16'd2);
        foreach (directed_row[i]) send_byte(directed_row[i]);
        drain();

        // Sender mostly busy, receiver mostly stalled.
        run_phase(16'd37, 16'd3, 40);

        // Sender mostly idle, receiver mostly ready; long rows reach the cap.
        src_idle_pct = 82;
        snk_idle_pct = 6;
        run_phase(16'd300, 16'd2, 60);
        run_phase(16'd1, 16'd32768, 15);

        // No idling from here on. First a long receiver hold-off while bytes
        // keep coming, so the block backs up into its input.
        src_idle_pct  = 0;
        snk_idle_pct  = 0;
        long_hold_req = 1'b1;
        run_phase(16'd500, 16'd1, 60);

        // Zero means full wrap for both counters; only part of such a row is
        // fed before the next setting ends it.
        run_phase(16'd0, 16'd0, 30);
        run_phase(16'd32768, 16'd65535, 15);
        run_phase(16'd45, 16'd5, 20);

        s_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
